// ----- src/mmes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmes_pkg
// shared types and constants of the multitrack midi event sequencer
// ----------------------------------------------------------------------------
package mmes_pkg;

	// input opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_FRAME = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SAMPLES_PER_TICK = 2'd0;
	localparam logic [1:0] REG_ACTIVE_TRACKS    = 2'd1;
	localparam logic [1:0] REG_LOOP_ENABLE      = 2'd2;

	// result kinds
	localparam logic KIND_EVENT   = 1'b0;
	localparam logic KIND_ALL_OFF = 1'b1;

	// stored event layout
	localparam int EV_W      = 53;
	localparam int DELTA_W   = 28;
	localparam int END_BIT   = 28;
	localparam int STATUS_LO = 29;
	localparam int DATA1_LO  = 37;
	localparam int DATA2_LO  = 45;

	localparam logic [31:0] DUE_NONE = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RW_RD,
		S_RW_WR,
		S_TK_RD,
		S_TK_LD,
		S_TK_CHK,
		S_TK_EV,
		S_TK_FE,
		S_TK_NX,
		S_TK_END,
		S_FIN
	} state_t;

endpackage

// ----- src/mmes_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmes_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mmes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/multitrack_midi_event_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitrack_midi_event_sequencer
// loads per-track event tables, counts audio frames and on every tick emits
// the midi events that fall due, walking the tracks with one sequencer
// ----------------------------------------------------------------------------
// channel   direction  handshake             contents
// cmd       in         cmd_valid/cmd_stall   opcode, load target and event
// res       out        res_valid/res_stall   kind, track, midi bytes, flags
// cfg       in         cfg_wr_en             cfg_index, cfg_data
//
// load and plain frame words are handled in idle; start rewinds all TRACKS tracks,
// a tick walks the active tracks and the events that fall due on them, plus
// a rewind of all TRACKS tracks when playback loops
// events are read one at a time through the single read port of the event ram
// cmd_stall is high while a word is being worked on; res stalls hold the
// sequencer only when a second result is ready behind the output register
// arst_n clears control state; the event ram is not cleared
// ----------------------------------------------------------------------------
module multitrack_midi_event_sequencer
	import mmes_pkg::*;
#(
	parameter int TRACKS           = 16,
	parameter int EVENTS_PER_TRACK = 1024,
	parameter int TICK_EVENT_LIMIT = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  track_sel,
	input  logic [9:0]  slot,
	input  logic [27:0] delta_time,
	input  logic        end_mark,
	input  logic [7:0]  status_in,
	input  logic [7:0]  first_data_in,
	input  logic [7:0]  second_data_in,
	input  logic        final_in_track,

	output logic        res_valid,
	input  logic        res_stall,
	output logic        kind,
	output logic [3:0]  source_track,
	output logic [7:0]  status_out,
	output logic [7:0]  first_data_out,
	output logic [7:0]  second_data_out,
	output logic        overflow,
	output logic        last
);

	localparam int TW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int IW   = $clog2(EVENTS_PER_TRACK + 1);
	localparam int EVD  = TRACKS * EVENTS_PER_TRACK;
	localparam int AW   = (EVD > 1) ? $clog2(EVD) : 1;
	localparam int CW   = $clog2(TRACKS + 1);
	localparam int NW   = (CW > 5) ? CW : 5;
	localparam int CNW  = $clog2(TICK_EVENT_LIMIT + 1);
	localparam int STW  = 32 + IW;
	localparam logic [AW-1:0] EPT_A = AW'(EVENTS_PER_TRACK);

	// control
	state_t           state_q, state_d;
	logic [TW-1:0]    trk_q, trk_d;
	logic [IW-1:0]    idx_q, idx_d;
	logic [31:0]      tick_q, tick_d;
	logic [15:0]      frame_q, frame_d;
	logic [4:0]       fin_q, fin_d;
	logic             started_q, started_d;
	logic             ended_q, ended_d;
	logic [CNW-1:0]   cnt_q, cnt_d;
	logic             over_q, over_d;
	logic             pend_vld_q, pend_vld_d;
	logic             res_valid_q, res_valid_d;
	logic [15:0]      spt_q;
	logic [4:0]       act_q;
	logic             loop_q;
	logic             len_vld_q [TRACKS];
	logic             len_vld_d [TRACKS];

	// payload
	logic [31:0]      due_q, due_d;
	logic [IW-1:0]    len_q, len_d;
	logic             len_ok_q, len_ok_d;
	logic             pend_kind_q, pend_kind_d;
	logic [3:0]       pend_trk_q, pend_trk_d;
	logic [7:0]       pend_st_q, pend_st_d;
	logic [7:0]       pend_d1_q, pend_d1_d;
	logic [7:0]       pend_d2_q, pend_d2_d;
	logic             kind_q, last_q, ovf_q;
	logic [3:0]       trk_out_q;
	logic [7:0]       st_out_q, d1_out_q, d2_out_q;

	// ram ports
	logic             ev_we;
	logic [AW-1:0]    ev_waddr, ev_raddr;
	logic [EV_W-1:0]  ev_wdata, ev_rdata;
	logic             st_we;
	logic [STW-1:0]   st_wdata, st_rdata;
	logic             len_we;
	logic [TW-1:0]    len_waddr;
	logic [IW-1:0]    len_wdata, len_rdata;

	logic             cmd_acc;
	logic             load_ok;
	logic             out_free;
	logic             out_load;
	logic             out_last;
	logic             out_ovf;
	logic [NW-1:0]    act_ext;
	logic [NW-1:0]    ntr;
	logic [IW-1:0]    idx_nx;
	logic [31:0]      due_nx;
	logic [15:0]      frame_nx;
	logic             ev_end;
	logic [DELTA_W-1:0] ev_delta;
	logic             below_limit;

	mmes_ram #(.WIDTH(EV_W), .DEPTH(EVD)) u_ev_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	mmes_ram #(.WIDTH(STW), .DEPTH(TRACKS)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (trk_q),
		.wdata (st_wdata),
		.raddr (trk_q),
		.rdata (st_rdata)
	);

	mmes_ram #(.WIDTH(IW), .DEPTH(TRACKS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (trk_q),
		.rdata (len_rdata)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign load_ok   = (32'(track_sel) < TRACKS) && (32'(slot) < EVENTS_PER_TRACK);
	assign out_free  = !res_valid_q || !res_stall;

	assign act_ext = NW'(act_q);
	assign ntr     = (act_ext > NW'(TRACKS)) ? NW'(TRACKS) : act_ext;

	assign ev_waddr  = AW'(track_sel) * EPT_A + AW'(slot);
	assign ev_wdata  = {second_data_in, first_data_in, status_in, end_mark, delta_time};
	assign ev_raddr  = AW'(trk_q) * EPT_A + AW'(idx_q);
	assign ev_end    = ev_rdata[END_BIT];
	assign ev_delta  = ev_rdata[DELTA_W-1:0];

	assign len_waddr = TW'(track_sel);
	assign len_wdata = IW'(slot) + IW'(1);

	assign idx_nx      = idx_q + IW'(1);
	assign due_nx      = tick_q + 32'(ev_delta);
	assign frame_nx    = frame_q + 16'd1;
	assign below_limit = (cnt_q < CNW'(TICK_EVENT_LIMIT));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q  <= 16'd1;
			act_q  <= 5'd1;
			loop_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SAMPLES_PER_TICK: spt_q  <= cfg_data;
				REG_ACTIVE_TRACKS:    act_q  <= cfg_data[4:0];
				REG_LOOP_ENABLE:      loop_q <= cfg_data[0];
				default:              ;
			endcase
		end
	end

	// sequencer next state and datapath
	always_comb begin
		state_d     = state_q;
		trk_d       = trk_q;
		idx_d       = idx_q;
		tick_d      = tick_q;
		frame_d     = frame_q;
		fin_d       = fin_q;
		started_d   = started_q;
		ended_d     = ended_q;
		cnt_d       = cnt_q;
		over_d      = over_q;
		pend_vld_d  = pend_vld_q;
		len_vld_d   = len_vld_q;
		due_d       = due_q;
		len_d       = len_q;
		len_ok_d    = len_ok_q;
		pend_kind_d = pend_kind_q;
		pend_trk_d  = pend_trk_q;
		pend_st_d   = pend_st_q;
		pend_d1_d   = pend_d1_q;
		pend_d2_d   = pend_d2_q;
		ev_we       = 1'b0;
		len_we      = 1'b0;
		st_we       = 1'b0;
		st_wdata    = {due_q, idx_q};
		out_load    = 1'b0;
		out_last    = 1'b0;
		out_ovf     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					priority if (opcode == OP_LOAD) begin
						if (load_ok) begin
							ev_we = 1'b1;
							if (final_in_track) begin
								len_we = 1'b1;
								len_vld_d[len_waddr] = 1'b1;
							end
						end
					end else if (opcode == OP_START) begin
						started_d   = 1'b1;
						ended_d     = 1'b0;
						frame_d     = 16'd0;
						over_d      = 1'b0;
						pend_vld_d  = 1'b1;
						pend_kind_d = KIND_ALL_OFF;
						pend_trk_d  = 4'd0;
						pend_st_d   = 8'd0;
						pend_d1_d   = 8'd0;
						pend_d2_d   = 8'd0;
						trk_d       = '0;
						idx_d       = '0;
						state_d     = S_RW_RD;
					end else if (opcode == OP_FRAME) begin
						if (started_q && !ended_q) begin
							if (frame_nx == spt_q) begin
								frame_d = 16'd0;
								cnt_d   = '0;
								over_d  = 1'b0;
								trk_d   = '0;
								state_d = (ntr == '0) ? S_TK_END : S_TK_RD;
							end else begin
								frame_d = frame_nx;
							end
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end

			S_RW_RD: state_d = S_RW_WR;

			S_RW_WR: begin
				st_we    = 1'b1;
				st_wdata = {32'(ev_delta), IW'(0)};
				if (trk_q == TW'(TRACKS - 1)) begin
					tick_d  = 32'd0;
					fin_d   = 5'd0;
					state_d = S_FIN;
				end else begin
					trk_d   = trk_q + TW'(1);
					state_d = S_RW_RD;
				end
			end

			S_TK_RD: begin
				len_ok_d = len_vld_q[trk_q];
				state_d  = S_TK_LD;
			end

			S_TK_LD: begin
				due_d   = st_rdata[STW-1:IW];
				idx_d   = st_rdata[IW-1:0];
				len_d   = len_ok_q ? len_rdata : '0;
				state_d = S_TK_CHK;
			end

			S_TK_CHK: begin
				if (due_q != DUE_NONE && due_q == tick_q) begin
					state_d = S_TK_EV;
				end else if (NW'(trk_q) + NW'(1) == ntr) begin
					state_d = S_TK_END;
				end else begin
					trk_d   = trk_q + TW'(1);
					state_d = S_TK_RD;
				end
			end

			S_TK_EV: begin
				if (!(!ev_end && below_limit && pend_vld_q && !out_free)) begin
					if (!ev_end) begin
						if (below_limit) begin
							out_load    = pend_vld_q;
							pend_vld_d  = 1'b1;
							pend_kind_d = KIND_EVENT;
							pend_trk_d  = 4'(trk_q);
							pend_st_d   = ev_rdata[STATUS_LO +: 8];
							pend_d1_d   = ev_rdata[DATA1_LO +: 8];
							pend_d2_d   = ev_rdata[DATA2_LO +: 8];
							cnt_d       = cnt_q + CNW'(1);
						end else begin
							over_d = 1'b1;
						end
					end
					idx_d = idx_nx;
					if (idx_nx < len_q) begin
						state_d = S_TK_FE;
					end else begin
						due_d    = DUE_NONE;
						st_we    = 1'b1;
						st_wdata = {DUE_NONE, idx_nx};
						fin_d    = fin_q + 5'd1;
						state_d  = S_TK_CHK;
					end
				end
			end

			S_TK_FE: state_d = S_TK_NX;

			S_TK_NX: begin
				due_d    = due_nx;
				st_we    = 1'b1;
				st_wdata = {due_nx, idx_q};
				state_d  = S_TK_CHK;
			end

			S_TK_END: begin
				tick_d  = tick_q + 32'd1;
				state_d = S_FIN;
				if (NW'(fin_q) == ntr) begin
					if (loop_q) begin
						trk_d   = '0;
						idx_d   = '0;
						state_d = S_RW_RD;
					end else begin
						ended_d = 1'b1;
					end
				end
			end

			S_FIN: begin
				if (!pend_vld_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last   = 1'b1;
					out_ovf    = over_q;
					pend_vld_d = 1'b0;
					state_d    = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase

		if (out_load) begin
			res_valid_d = 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			trk_q       <= '0;
			idx_q       <= '0;
			tick_q      <= 32'd0;
			frame_q     <= 16'd0;
			fin_q       <= 5'd0;
			started_q   <= 1'b0;
			ended_q     <= 1'b0;
			cnt_q       <= '0;
			over_q      <= 1'b0;
			pend_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < TRACKS; i++) begin
				len_vld_q[i] <= 1'b0;
			end
		end else begin
			state_q     <= state_d;
			trk_q       <= trk_d;
			idx_q       <= idx_d;
			tick_q      <= tick_d;
			frame_q     <= frame_d;
			fin_q       <= fin_d;
			started_q   <= started_d;
			ended_q     <= ended_d;
			cnt_q       <= cnt_d;
			over_q      <= over_d;
			pend_vld_q  <= pend_vld_d;
			res_valid_q <= res_valid_d;
			len_vld_q   <= len_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		due_q       <= due_d;
		len_q       <= len_d;
		len_ok_q    <= len_ok_d;
		pend_kind_q <= pend_kind_d;
		pend_trk_q  <= pend_trk_d;
		pend_st_q   <= pend_st_d;
		pend_d1_q   <= pend_d1_d;
		pend_d2_q   <= pend_d2_d;
		if (out_load) begin
			kind_q    <= pend_kind_q;
			trk_out_q <= pend_trk_q;
			st_out_q  <= pend_st_q;
			d1_out_q  <= pend_d1_q;
			d2_out_q  <= pend_d2_q;
			ovf_q     <= out_ovf;
			last_q    <= out_last;
		end
	end

	assign res_valid       = res_valid_q;
	assign kind            = kind_q;
	assign source_track    = trk_out_q;
	assign status_out      = st_out_q;
	assign first_data_out  = d1_out_q;
	assign second_data_out = d2_out_q;
	assign overflow        = ovf_q;
	assign last            = last_q;

endmodule

// ----- src/mmes_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmes_checker
// port level checks of the multitrack midi event sequencer
// ----------------------------------------------------------------------------
module mmes_checker
	import mmes_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic [1:0]  opcode,
	input logic        res_valid,
	input logic        res_stall,
	input logic        kind,
	input logic [3:0]  source_track,
	input logic [7:0]  status_out,
	input logic [7:0]  first_data_out,
	input logic [7:0]  second_data_out,
	input logic        overflow,
	input logic        last
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(source_track)
			&& $stable(status_out) && $stable(first_data_out)
			&& $stable(second_data_out) && $stable(overflow) && $stable(last))
		else $error("result word changed while stalled");

	// all voices off is a single clean word
	a_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_ALL_OFF |-> last && !overflow && source_track == 4'd0
			&& status_out == 8'd0 && first_data_out == 8'd0 && second_data_out == 8'd0)
		else $error("bad all voices off word");

	// overflow only marks the closing word of a tick
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> last && kind == KIND_EVENT)
		else $error("overflow on a word that does not close a tick");

	// start always runs the rewind sweep
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && opcode == OP_START |=> cmd_stall)
		else $error("start word did not occupy the sequencer");

endmodule

bind multitrack_midi_event_sequencer mmes_checker u_mmes_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// sends load, start, frame and unknown opcode words to the midi event sequencer and keeps
// its own copy of the event tables, track pointers and tick position.
// every voices-off and due event is checked in order against that copy,
// under random sender gaps, output stalls and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;
	import mmes_pkg::*;

	localparam int NTRK        = 16;
	localparam int NSLOT       = 1024;
	localparam int EV_LIMIT    = 64;
	localparam int WORD_TARGET = 480;
	localparam int SETTLE      = 1000;
	localparam int HOLD_CYCLES = 800;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [1:0] OP_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  trk;
		logic [9:0]  slot;
		logic [27:0] delta;
		logic        endm;
		logic [7:0]  st;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic        fin;
	} seq_word_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] trk;
		logic [7:0] st;
		logic [7:0] d1;
		logic [7:0] d2;
		logic       ovf;
		logic       lst;
	} midi_msg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  opcode = '0;
	logic [3:0]  track_sel = '0;
	logic [9:0]  slot = '0;
	logic [27:0] delta_time = '0;
	logic        end_mark = 1'b0;
	logic [7:0]  status_in = '0;
	logic [7:0]  first_data_in = '0;
	logic [7:0]  second_data_in = '0;
	logic        final_in_track = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        kind;
	logic [3:0]  source_track;
	logic [7:0]  status_out;
	logic [7:0]  first_data_out;
	logic [7:0]  second_data_out;
	logic        overflow;
	logic        last;

	// sequencer copy
	logic [EV_W-1:0] song_mem [NTRK*NSLOT];
	logic [10:0]     trk_len [NTRK];
	logic [31:0]     due_at [NTRK];
	logic [10:0]     ev_idx [NTRK];
	logic [31:0]     song_tick;
	logic [15:0]     frame_cnt;
	logic [4:0]      done_cnt;
	bit              play_on;
	bit              play_over;
	logic [15:0]     cfg_spt = 16'd1;
	logic [4:0]      cfg_tracks = 5'd1;
	logic            cfg_loop = 1'b0;

	seq_word_t cmd_fifo[$];
	midi_msg_t due_msgs[$];
	seq_word_t offered;
	bit        loaded [NTRK*NSLOT];
	int        words_queued = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	int        hold_req = 0;
	int        hold_ack = 0;
	int        hold_left = 0;
	int        mismatch_cnt = 0;
	int        cycle_cnt = 0;

	multitrack_midi_event_sequencer #(
		.TRACKS(NTRK),
		.EVENTS_PER_TRACK(NSLOT),
		.TICK_EVENT_LIMIT(EV_LIMIT)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void rewind_song();
		for (int t = 0; t < NTRK; t++) begin
			due_at[t] = {4'd0, song_mem[t*NSLOT][DELTA_W-1:0]};
			ev_idx[t] = '0;
		end
		song_tick = '0;
		done_cnt = '0;
	endfunction

	function automatic void tick_tracks();
		int ntr;
		int n;
		bit over;
		logic [EV_W-1:0] ev;
		midi_msg_t m;
		ntr = (cfg_tracks > NTRK) ? NTRK : int'(cfg_tracks);
		n = 0;
		over = 1'b0;
		for (int t = 0; t < ntr; t++) begin
			while (due_at[t] != DUE_NONE && due_at[t] == song_tick) begin
				ev = song_mem[t*NSLOT + int'(ev_idx[t])];
				if (!ev[END_BIT]) begin
					if (n < EV_LIMIT) begin
						m = '0;
						m.kind = KIND_EVENT;
						m.trk = 4'(t);
						m.st = ev[STATUS_LO +: 8];
						m.d1 = ev[DATA1_LO +: 8];
						m.d2 = ev[DATA2_LO +: 8];
						due_msgs.push_back(m);
						n++;
					end else begin
						over = 1'b1;
					end
				end
				ev_idx[t] = ev_idx[t] + 11'd1;
				if (ev_idx[t] < trk_len[t]) begin
					due_at[t] = song_tick
						+ {4'd0, song_mem[t*NSLOT + int'(ev_idx[t])][DELTA_W-1:0]};
				end else begin
					due_at[t] = DUE_NONE;
					done_cnt = done_cnt + 5'd1;
				end
			end
		end
		song_tick = song_tick + 32'd1;
		if (done_cnt == ntr) begin
			if (cfg_loop)
				rewind_song();
			else
				play_over = 1'b1;
		end
		if (n > 0) begin
			m = due_msgs.pop_back();
			m.ovf = over;
			m.lst = 1'b1;
			due_msgs.push_back(m);
		end
	endfunction

	function automatic void sequence_word(seq_word_t w);
		midi_msg_t m;
		case (w.op)
			OP_LOAD: begin
				song_mem[int'(w.trk)*NSLOT + int'(w.slot)] = {w.d2, w.d1, w.st, w.endm, w.delta};
				if (w.fin)
					trk_len[w.trk] = {1'b0, w.slot} + 11'd1;
			end
			OP_START: begin
				rewind_song();
				frame_cnt = '0;
				play_on = 1'b1;
				play_over = 1'b0;
				m = '0;
				m.kind = KIND_ALL_OFF;
				m.lst = 1'b1;
				due_msgs.push_back(m);
			end
			OP_FRAME: begin
				if (play_on && !play_over) begin
					frame_cnt = frame_cnt + 16'd1;
					if (frame_cnt == cfg_spt) begin
						frame_cnt = '0;
						tick_tracks();
					end
				end
			end
			default: ;
		endcase
	endfunction

	// command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall)
				sequence_word(offered);
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = cmd_fifo.pop_front();
					cmd_valid <= 1'b1;
					opcode <= offered.op;
					track_sel <= offered.trk;
					slot <= offered.slot;
					delta_time <= offered.delta;
					end_mark <= offered.endm;
					status_in <= offered.st;
					first_data_in <= offered.d1;
					second_data_in <= offered.d2;
					final_in_track <= offered.fin;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result stall, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		midi_msg_t got;
		midi_msg_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = {kind, source_track, status_out, first_data_out, second_data_out,
				overflow, last};
			if (due_msgs.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("unexpected word: kind=%0d trk=%0d st=%h d1=%h d2=%h ovf=%0d last=%0d",
						got.kind, got.trk, got.st, got.d1, got.d2, got.ovf, got.lst);
				mismatch_cnt++;
			end else begin
				want = due_msgs.pop_front();
				if (got !== want) begin
					if (mismatch_cnt < 10) begin
						$display("mismatch: exp kind=%0d trk=%0d st=%h d1=%h d2=%h ovf=%0d last=%0d",
							want.kind, want.trk, want.st, want.d1, want.d2, want.ovf, want.lst);
						$display("          got kind=%0d trk=%0d st=%h d1=%h d2=%h ovf=%0d last=%0d",
							got.kind, got.trk, got.st, got.d1, got.d2, got.ovf, got.lst);
					end
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int filled_run(int trk);
		int run;
		run = 0;
		while (run < NSLOT && loaded[trk*NSLOT + run])
			run++;
		return run;
	endfunction

	// final_in_track only where every slot below is already loaded
	task automatic push_word(logic [1:0] op, logic [3:0] trk, logic [9:0] slt,
			logic [27:0] delta, logic endm, logic [7:0] st, logic [7:0] d1,
			logic [7:0] d2, logic fin);
		seq_word_t w;
		w = {op, trk, slt, delta, endm, st, d1, d2, fin};
		if (op == OP_LOAD) begin
			loaded[int'(trk)*NSLOT + int'(slt)] = 1'b1;
			if (filled_run(int'(trk)) <= int'(slt))
				w.fin = 1'b0;
		end
		cmd_fifo.push_back(w);
		words_queued++;
	endtask

	task automatic push_ctrl(logic [1:0] op);
		push_word(op, 4'($urandom), 10'($urandom), 28'($urandom), 1'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic push_load(logic [3:0] trk, logic [9:0] slt, logic [27:0] delta,
			logic endm, logic fin);
		push_word(OP_LOAD, trk, slt, delta, endm, 8'($urandom), 8'($urandom),
			8'($urandom), fin);
	endtask

	function automatic logic [27:0] song_delta();
		if ($urandom_range(39) == 0)
			return 28'($urandom);
		return 28'($urandom_range(3));
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SAMPLES_PER_TICK: cfg_spt = val;
			REG_ACTIVE_TRACKS: cfg_tracks = val[4:0];
			REG_LOOP_ENABLE: cfg_loop = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			1: begin
				send_idle_pct = 69;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 69;
			end
			3: begin
				send_idle_pct = 23;
				stall_pct = 23;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (cmd_fifo.size() != 0 || cmd_valid || due_msgs.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic song_phase(int n_load, int spt);
		int span;
		int len;
		int sum;
		int frames;
		int r;
		int trk;
		int top;
		logic [27:0] dt;
		span = 0;
		for (int t = 0; t < n_load; t++) begin
			len = $urandom_range(1, (n_load > 8) ? 3 : 6);
			sum = 0;
			for (int s = 0; s < len; s++) begin
				dt = song_delta();
				if (dt < 8)
					sum += int'(dt);
				push_load(4'(t), 10'(s), dt, $urandom_range(5) == 0, s == len - 1);
			end
			if (sum > span)
				span = sum;
		end
		if ($urandom_range(2) == 0)
			push_load(4'($urandom), 10'($urandom), 28'($urandom), 1'($urandom),
				1'($urandom));
		push_ctrl(OP_START);
		frames = spt * (span + 3);
		if (frames > 40)
			frames = 40;
		for (int i = 0; i < frames; i++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				push_ctrl(OP_IGNORED);
			end else if (r < 10) begin
				trk = $urandom_range(NTRK - 1);
				top = filled_run(trk);
				if (top >= NSLOT)
					top = NSLOT - 1;
				push_load(4'(trk), 10'($urandom_range(top)), song_delta(),
					$urandom_range(5) == 0, $urandom_range(3) == 0);
			end else if (r < 13) begin
				push_ctrl(OP_START);
			end else begin
				push_ctrl(OP_FRAME);
			end
		end
	endtask

	initial begin
		int ph;
		int act;
		int spt;
		int base;
		for (int t = 0; t < NTRK; t++) begin
			trk_len[t] = '0;
			due_at[t] = DUE_NONE;
			ev_idx[t] = '0;
		end
		song_tick = '0;
		frame_cnt = '0;
		done_cnt = '0;
		play_on = 1'b0;
		play_over = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// idle frame, unknown opcode, slot 0 of every track, empty track play
		set_idling(0);
		push_ctrl(OP_FRAME);
		push_ctrl(OP_IGNORED);
		push_word(OP_LOAD, 4'd0, 10'd0, 28'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
		push_word(OP_LOAD, 4'd15, 10'd1023, 28'hFFFFFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		for (int t = 1; t < NTRK; t++)
			push_word(OP_LOAD, 4'(t), 10'd0,
				(t == NTRK - 1) ? 28'hFFFFFFF : 28'($urandom_range(3)),
				t[0], 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		push_ctrl(OP_START);
		push_ctrl(OP_FRAME);
		push_ctrl(OP_FRAME);
		push_ctrl(OP_IGNORED);
		drain();

		base = words_queued;
		ph = 0;
		while (words_queued < base + WORD_TARGET) begin
			ph++;
			set_idling(ph % 4);
			if (ph == 2) begin
				// one tick past the event limit while the output is held off
				write_reg(REG_SAMPLES_PER_TICK, 16'd1);
				write_reg(REG_ACTIVE_TRACKS, 16'd2);
				write_reg(REG_LOOP_ENABLE, 16'd0);
				for (int s = 0; s < 70; s++)
					push_word(OP_LOAD, 4'd0, 10'(s), (s == 0) ? 28'd1 : 28'd0, 1'b0,
						8'($urandom), 8'($urandom), 8'($urandom), s == 69);
				for (int s = 0; s < 3; s++)
					push_word(OP_LOAD, 4'd1, 10'(s), (s == 0) ? 28'd1 : 28'd0, 1'b0,
						8'($urandom), 8'($urandom), 8'($urandom), s == 2);
				hold_req++;
				push_ctrl(OP_START);
				repeat (4) push_ctrl(OP_FRAME);
			end else if (ph == 3 || ph == 6) begin
				write_reg(REG_SAMPLES_PER_TICK, (ph == 3) ? 16'hFFFF : 16'd0);
				write_reg(REG_ACTIVE_TRACKS, 16'($urandom_range(1, NTRK)));
				write_reg(REG_LOOP_ENABLE, 16'($urandom_range(1)));
				push_ctrl(OP_START);
				repeat (6) push_ctrl(OP_FRAME);
				push_ctrl(OP_IGNORED);
			end else begin
				spt = $urandom_range(1, 3);
				case (ph)
					4: act = 16;
					8: act = 0;
					9: act = 31;
					10: act = 17;
					default: act = $urandom_range(1, NTRK);
				endcase
				write_reg(REG_SAMPLES_PER_TICK, 16'(spt));
				write_reg(REG_ACTIVE_TRACKS, 16'(act));
				write_reg(REG_LOOP_ENABLE, 16'(ph % 2));
				song_phase((act == 0) ? 1 : ((act > NTRK) ? NTRK : act), spt);
			end
			drain();
		end

		if (mismatch_cnt == 0 && due_msgs.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
